// ===== design/smbc_pkg.sv =====
// Shared types, codes and box shape tables for the sprite mover.
`timescale 1ns / 1ps
`default_nettype none
package smbc_pkg;

	localparam int SPR_SIZE  = 20;
	localparam int BOX_COUNT = 11;
	localparam int VEL_LIMIT = 64;

	typedef logic [3:0] box_idx_t;
	typedef logic [4:0] box_ofs_t;

	localparam box_idx_t BOX_LAST = box_idx_t'(BOX_COUNT - 1);

	// request codes
	localparam logic [1:0] REQ_PRESS   = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_TICK    = 2'd2;

	// key directions
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_STEP_SPEED = 2'd0;
	localparam logic [1:0] CFG_OTHER_X    = 2'd1;
	localparam logic [1:0] CFG_OTHER_Y    = 2'd2;

	// box edges relative to the sprite's top-left corner
	function automatic box_ofs_t box_left(input box_idx_t k);
		box_ofs_t r;
		unique case (k)
			4'd0, 4'd10: r = 5'd7;
			4'd1, 4'd9:  r = 5'd5;
			4'd2, 4'd8:  r = 5'd3;
			4'd3, 4'd7:  r = 5'd2;
			4'd4, 4'd6:  r = 5'd1;
			default:     r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic box_ofs_t box_right(input box_idx_t k);
		return box_ofs_t'(SPR_SIZE) - box_left(k);
	endfunction

	function automatic box_ofs_t box_top(input box_idx_t k);
		box_ofs_t r;
		unique case (k)
			4'd0:    r = 5'd0;
			4'd1:    r = 5'd1;
			4'd2:    r = 5'd2;
			4'd3:    r = 5'd3;
			4'd4:    r = 5'd5;
			4'd5:    r = 5'd7;
			4'd6:    r = 5'd13;
			4'd7:    r = 5'd15;
			4'd8:    r = 5'd17;
			4'd9:    r = 5'd18;
			default: r = 5'd19;
		endcase
		return r;
	endfunction

	function automatic box_ofs_t box_bot(input box_idx_t k);
		box_ofs_t r;
		unique case (k)
			4'd0:    r = 5'd1;
			4'd1:    r = 5'd2;
			4'd2:    r = 5'd3;
			4'd3:    r = 5'd5;
			4'd4:    r = 5'd7;
			4'd5:    r = 5'd13;
			4'd6:    r = 5'd15;
			4'd7:    r = 5'd17;
			4'd8:    r = 5'd18;
			4'd9:    r = 5'd19;
			default: r = 5'd20;
		endcase
		return r;
	endfunction

	// velocity update with saturation at +/- VEL_LIMIT
	function automatic logic signed [7:0] vel_step(input logic signed [7:0] v,
			input logic [3:0] sp, input logic sub);
		logic signed [8:0] s;
		logic signed [7:0] r;
		s = sub ? (9'(v) - $signed({5'd0, sp})) : (9'(v) + $signed({5'd0, sp}));
		if (s > 9'sd64)
			r = 8'sd64;
		else if (s < -9'sd64)
			r = -8'sd64;
		else
			r = s[7:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/smbc_if.sv =====
// Handshake channels: request, result and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface smbc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [1:0] direction;
	logic       is_repeat;
	modport source (output valid, output req_type, output direction, output is_repeat,
		input ready);
	modport sink (input valid, input req_type, input direction, input is_repeat,
		output ready);
endinterface

interface smbc_res_if;
	logic              valid;
	logic              ready;
	logic [9:0]        pos_x;
	logic [8:0]        pos_y;
	logic signed [7:0] vel_x;
	logic signed [7:0] vel_y;
	logic              blocked_x;
	logic              blocked_y;
	modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
		output blocked_x, output blocked_y, input ready);
	modport sink (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
		input blocked_x, input blocked_y, output ready);
endinterface

interface smbc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [9:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/smbc_pair_test.sv =====
// Overlap test of one box pair given the offset between the two sprites.
`timescale 1ns / 1ps
`default_nettype none
module smbc_pair_test
	import smbc_pkg::*;
#(
	parameter int DW = 13
) (
	input  wire logic signed [DW-1:0] dx,
	input  wire logic signed [DW-1:0] dy,
	input  wire box_idx_t             idx_a,
	input  wire box_idx_t             idx_b,
	output logic                      hit
);
	function automatic logic signed [DW-1:0] ext(input box_ofs_t v);
		return DW'($signed({1'b0, v}));
	endfunction

	logic sep_y0, sep_y1, sep_x0, sep_x1;

	// strict separation: a touching edge is no overlap
	assign sep_y0 = (dy + ext(box_bot(idx_a)))   <= ext(box_top(idx_b));
	assign sep_y1 = (dy + ext(box_top(idx_a)))   >= ext(box_bot(idx_b));
	assign sep_x0 = (dx + ext(box_right(idx_a))) <= ext(box_left(idx_b));
	assign sep_x1 = (dx + ext(box_left(idx_a)))  >= ext(box_right(idx_b));
	assign hit = !(sep_y0 || sep_y1 || sep_x0 || sep_x1);
endmodule
`default_nettype wire

// ===== design/sprite_move_with_box_collision.sv =====
// Top level: sprite position/velocity keeper with box-set collision against one obstacle.
`timescale 1ns / 1ps
`default_nettype none
// Sprite mover. Key beats (press/release, non-repeat) add or subtract step_speed on
// one velocity axis, saturating at +/-64. A tick beat moves along x, then along y;
// each move is undone if the sprite leaves the field or any of its 11 row boxes
// overlaps a box of the obstacle at (other_x, other_y). The overlap check runs
// through one shared pair-test unit, one box pair per cycle, and stops at the
// first hit or when the move leaves the field. Request type 3 and repeat keys
// change nothing but still return a result. The input is held off (req.ready low)
// while an item is in work; one finished result may wait in the output register
// while the next beat is accepted. Config writes are always taken and should only
// be issued while the block is idle.
module sprite_move_with_box_collision
	import smbc_pkg::*;
#(
	parameter int FIELD_WIDTH  = 640,
	parameter int FIELD_HEIGHT = 480
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	smbc_req_if.sink   req,
	smbc_res_if.source res,
	smbc_cfg_if.sink   cfg
);
	localparam int XW  = $clog2(FIELD_WIDTH);
	localparam int YW  = $clog2(FIELD_HEIGHT);
	localparam int MW  = (XW > YW) ? XW : YW;
	localparam int DW  = ((MW > 10) ? MW : 10) + 3;
	localparam logic signed [DW-1:0] X_MAX = DW'(FIELD_WIDTH - SPR_SIZE);
	localparam logic signed [DW-1:0] Y_MAX = DW'(FIELD_HEIGHT - SPR_SIZE);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic              axis_q;      // 0: x move, 1: y move
	box_idx_t          ia_q, ib_q;
	logic signed [DW-1:0] cand_q, dx_q, dy_q;
	logic              oob_q;

	logic [XW-1:0]     sx_q;
	logic [YW-1:0]     sy_q;
	logic signed [7:0] vx_q, vy_q;
	logic              bx_q, by_q;

	logic [3:0]        step_speed_q;
	logic [9:0]        other_x_q;
	logic [8:0]        other_y_q;

	logic              ovalid_q;
	logic [9:0]        o_pos_x_q;
	logic [8:0]        o_pos_y_q;
	logic signed [7:0] o_vel_x_q, o_vel_y_q;
	logic              o_bx_q, o_by_q;

	// setup arithmetic
	logic signed [DW-1:0] sx_e, sy_e, ox_e, oy_e, nx, ny;
	logic                 pair_hit, last_pair, out_free, key_sub, in_acc;

	assign sx_e = DW'($signed({1'b0, sx_q}));
	assign sy_e = DW'($signed({1'b0, sy_q}));
	assign ox_e = DW'($signed({1'b0, other_x_q}));
	assign oy_e = DW'($signed({1'b0, other_y_q}));
	assign nx   = sx_e + DW'(vx_q);
	assign ny   = sy_e + DW'(vy_q);

	assign last_pair = (ia_q == BOX_LAST) && (ib_q == BOX_LAST);
	assign out_free  = !ovalid_q || res.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// up/left press and down/right release move the velocity negative
	assign key_sub = ((req.direction == DIR_UP) || (req.direction == DIR_LEFT))
		^ (req.req_type == REQ_RELEASE);

	smbc_pair_test #(.DW(DW)) u_pair (
		.dx    (dx_q),
		.dy    (dy_q),
		.idx_a (ia_q),
		.idx_b (ib_q),
		.hit   (pair_hit)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_speed_q <= 4'd1;
			other_x_q    <= 10'd160;
			other_y_q    <= 9'd120;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_STEP_SPEED: step_speed_q <= cfg.data[3:0];
				CFG_OTHER_X:    other_x_q    <= cfg.data;
				CFG_OTHER_Y:    other_y_q    <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	// sequencer and sprite state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
			sx_q    <= '0;
			sy_q    <= '0;
			vx_q    <= '0;
			vy_q    <= '0;
			bx_q    <= 1'b0;
			by_q    <= 1'b0;
			ia_q    <= '0;
			ib_q    <= '0;
			cand_q  <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			oob_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						bx_q   <= 1'b0;
						by_q   <= 1'b0;
						axis_q <= 1'b0;
						if (req.req_type == REQ_TICK) begin
							state_q <= ST_SETUP;
						end else begin
							state_q <= ST_DONE;
							if (((req.req_type == REQ_PRESS) || (req.req_type == REQ_RELEASE))
									&& !req.is_repeat) begin
								if ((req.direction == DIR_UP) || (req.direction == DIR_DOWN))
									vy_q <= vel_step(vy_q, step_speed_q, key_sub);
								else
									vx_q <= vel_step(vx_q, step_speed_q, key_sub);
							end
						end
					end
				end
				ST_SETUP: begin
					// candidate position and offset to the obstacle for this axis
					ia_q    <= '0;
					ib_q    <= '0;
					state_q <= ST_SCAN;
					if (!axis_q) begin
						cand_q <= nx;
						dx_q   <= nx - ox_e;
						dy_q   <= sy_e - oy_e;
						oob_q  <= (nx < 0) || (nx > X_MAX);
					end else begin
						cand_q <= ny;
						dx_q   <= sx_e - ox_e;
						dy_q   <= ny - oy_e;
						oob_q  <= (ny < 0) || (ny > Y_MAX);
					end
				end
				ST_SCAN: begin
					if (oob_q || pair_hit || last_pair) begin
						// blocked moves leave the position alone
						if (!axis_q) begin
							bx_q <= oob_q || pair_hit;
							if (!(oob_q || pair_hit))
								sx_q <= cand_q[XW-1:0];
							axis_q  <= 1'b1;
							state_q <= ST_SETUP;
						end else begin
							by_q <= oob_q || pair_hit;
							if (!(oob_q || pair_hit))
								sy_q <= cand_q[YW-1:0];
							state_q <= ST_DONE;
						end
					end else if (ib_q == BOX_LAST) begin
						ib_q <= '0;
						ia_q <= ia_q + box_idx_t'(1);
					end else begin
						ib_q <= ib_q + box_idx_t'(1);
					end
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			ovalid_q <= 1'b1;
		end else if (res.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			o_pos_x_q <= 10'(sx_q);
			o_pos_y_q <= 9'(sy_q);
			o_vel_x_q <= vx_q;
			o_vel_y_q <= vy_q;
			o_bx_q    <= bx_q;
			o_by_q    <= by_q;
		end
	end

	assign res.valid     = ovalid_q;
	assign res.pos_x     = o_pos_x_q;
	assign res.pos_y     = o_pos_y_q;
	assign res.vel_x     = o_vel_x_q;
	assign res.vel_y     = o_vel_y_q;
	assign res.blocked_x = o_bx_q;
	assign res.blocked_y = o_by_q;
endmodule
`default_nettype wire

// ===== bench/sprite_move_with_box_collision_tb.sv =====
// Testbench for the sprite mover: directed table, then random phases checked by a predictor.
`timescale 1ns / 1ps
module sprite_move_with_box_collision_tb;
	import smbc_pkg::*;

	localparam int FIELD_W = 640;
	localparam int FIELD_H = 480;
	// request code the block must treat as a no-op
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// tail wait after the last result
	localparam int TAIL_CYCLES = 300;
	// slowest run: ~480 beats with the largest gaps, work and stalls, plus two long holds
	localparam int CYCLE_LIMIT = 400_000;
	localparam int HOLD_CYCLES = 700;
	localparam int PHASES = 12;
	localparam int BEATS_PER_PHASE = 38;

	typedef struct packed {
		logic [9:0]        pos_x;
		logic [8:0]        pos_y;
		logic signed [7:0] vel_x;
		logic signed [7:0] vel_y;
		logic              blocked_x;
		logic              blocked_y;
	} move_res_t;

	// one row of the directed table: a request beat or a register write
	typedef struct {
		bit         is_reg;
		logic [1:0] rtype;
		logic [1:0] dir;
		logic       rep;
		bit         typed;
		move_res_t  want;
		logic [1:0] reg_idx;
		logic [9:0] reg_val;
	} stim_row_t;

	logic clk;
	logic arst_n;

	smbc_req_if req_ch ();
	smbc_res_if res_ch ();
	smbc_cfg_if cfg_ch ();

	sprite_move_with_box_collision #(
		.FIELD_WIDTH (FIELD_W),
		.FIELD_HEIGHT(FIELD_H)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// predicted sprite state and register shadow
	int sprite_px = 0;
	int sprite_py = 0;
	int speed_vx  = 0;
	int speed_vy  = 0;
	int step_amt  = 1;
	int obst_x    = 160;
	int obst_y    = 120;

	move_res_t pending_res[$];
	stim_row_t directed[$];
	int        mismatches = 0;
	int        beats_sent = 0;
	int        beats_taken = 0;
	int        cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run guard
	initial begin
		forever @(posedge clk) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// row shape: widths and heights of the 11 stacked boxes
	function automatic int box_width(input int k);
		case (k)
			0, 10:   return 6;
			1, 9:    return 10;
			2, 8:    return 14;
			3, 7:    return 16;
			4, 6:    return 18;
			default: return 20;
		endcase
	endfunction

	function automatic int box_height(input int k);
		case (k)
			3, 4, 6, 7: return 2;
			5:          return 6;
			default:    return 1;
		endcase
	endfunction

	function automatic int sat_vel(input int v);
		if (v > VEL_LIMIT)
			return VEL_LIMIT;
		if (v < -VEL_LIMIT)
			return -VEL_LIMIT;
		return v;
	endfunction

	// strict rectangle test over every box pair of the two sprites
	function automatic bit sprites_touch(input int ax, input int ay, input int bx, input int by);
		int row_a;
		int row_b;
		int la, ra, ta, ba, lb, rb, tb, bb;
		row_a = 0;
		for (int i = 0; i < BOX_COUNT; i++) begin
			la = ax + (SPR_SIZE - box_width(i)) / 2;
			ra = la + box_width(i);
			ta = ay + row_a;
			ba = ta + box_height(i);
			row_b = 0;
			for (int j = 0; j < BOX_COUNT; j++) begin
				lb = bx + (SPR_SIZE - box_width(j)) / 2;
				rb = lb + box_width(j);
				tb = by + row_b;
				bb = tb + box_height(j);
				if (!(ba <= tb || ta >= bb || ra <= lb || la >= rb))
					return 1'b1;
				row_b += box_height(j);
			end
			row_a += box_height(i);
		end
		return 1'b0;
	endfunction

	// advance the predicted state by one request beat, return its result
	function automatic move_res_t apply_beat(input logic [1:0] rtype, input logic [1:0] dir,
			input logic rep);
		int delta;
		int nx, ny;
		move_res_t r;
		r.blocked_x = 1'b0;
		r.blocked_y = 1'b0;
		if ((rtype == REQ_PRESS || rtype == REQ_RELEASE) && !rep) begin
			delta = (rtype == REQ_PRESS) ? step_amt : -step_amt;
			case (dir)
				DIR_UP:    speed_vy = sat_vel(speed_vy - delta);
				DIR_DOWN:  speed_vy = sat_vel(speed_vy + delta);
				DIR_LEFT:  speed_vx = sat_vel(speed_vx - delta);
				DIR_RIGHT: speed_vx = sat_vel(speed_vx + delta);
			endcase
		end else if (rtype == REQ_TICK) begin
			// x first, then y from the (possibly updated) x
			nx = sprite_px + speed_vx;
			if (nx < 0 || nx + SPR_SIZE > FIELD_W || sprites_touch(nx, sprite_py, obst_x, obst_y))
				r.blocked_x = 1'b1;
			else
				sprite_px = nx;
			ny = sprite_py + speed_vy;
			if (ny < 0 || ny + SPR_SIZE > FIELD_H || sprites_touch(sprite_px, ny, obst_x, obst_y))
				r.blocked_y = 1'b1;
			else
				sprite_py = ny;
		end
		r.pos_x = sprite_px[9:0];
		r.pos_y = sprite_py[8:0];
		r.vel_x = speed_vx[7:0];
		r.vel_y = speed_vy[7:0];
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Directed table builders
	// ---------------------------------------------------------------------

	function automatic void add_key(input logic [1:0] rtype, input logic [1:0] dir,
			input logic rep);
		stim_row_t row;
		row = '{default: '0};
		row.rtype = rtype;
		row.dir = dir;
		row.rep = rep;
		directed.push_back(row);
	endfunction

	// beat whose result is obvious enough to write down
	function automatic void add_chk(input logic [1:0] rtype, input logic [1:0] dir,
			input logic rep, input int px, input int py, input int vx, input int vy,
			input bit bx, input bit by);
		stim_row_t row;
		row = '{default: '0};
		row.rtype = rtype;
		row.dir = dir;
		row.rep = rep;
		row.typed = 1'b1;
		row.want.pos_x = px[9:0];
		row.want.pos_y = py[8:0];
		row.want.vel_x = vx[7:0];
		row.want.vel_y = vy[7:0];
		row.want.blocked_x = bx;
		row.want.blocked_y = by;
		directed.push_back(row);
	endfunction

	function automatic void add_reg(input logic [1:0] idx, input int val);
		stim_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val[9:0];
		directed.push_back(row);
	endfunction

	// gap draw: every fourth block of 40 beats runs back to back
	function automatic int pick_gap(input int n);
		if ((n / 40) % 4 == 3)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------

	// offer one request beat; the expectation is queued at the accepting edge
	task automatic send_beat(input logic [1:0] rtype, input logic [1:0] dir, input logic rep,
			input bit typed, input move_res_t want);
		int gap;
		move_res_t pred;
		gap = pick_gap(beats_sent);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= rtype;
		req_ch.direction <= dir;
		req_ch.is_repeat <= rep;
		do @(posedge clk); while (!req_ch.ready);
		pred = apply_beat(rtype, dir, rep);
		pending_res.push_back(typed ? want : pred);
		beats_sent++;
	endtask

	// drop valid and wait until every expected result has been taken
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_STEP_SPEED: step_amt = int'(val[3:0]);
			CFG_OTHER_X:    obst_x = int'(val);
			CFG_OTHER_Y:    obst_y = int'(val[8:0]);
			default:        ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Result side: random stalls, two long hold-offs, field-by-field check
	// ---------------------------------------------------------------------
	initial begin
		int stall;
		move_res_t want;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			// long hold-off lets the block fill its output register and stall req
			if (beats_taken == 100 || beats_taken == 330)
				stall = HOLD_CYCLES;
			else
				stall = pick_gap(beats_taken + 20);
			if (stall > 0) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			beats_taken++;
			if (pending_res.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual x=%0d y=%0d",
					$time, res_ch.pos_x, res_ch.pos_y);
				mismatches++;
			end else begin
				want = pending_res.pop_front();
				check_field("pos_x", want.pos_x, res_ch.pos_x);
				check_field("pos_y", want.pos_y, res_ch.pos_y);
				check_field("vel_x", want.vel_x, res_ch.vel_x);
				check_field("vel_y", want.vel_y, res_ch.vel_y);
				check_field("blocked_x", want.blocked_x, res_ch.blocked_x);
				check_field("blocked_y", want.blocked_y, res_ch.blocked_y);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [1:0] rtype;
		logic [1:0] dir;
		logic       rep;
		int         sel;
		int         ox, oy;
		move_res_t  none;

		none = '0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_PRESS;
		req_ch.direction <= DIR_UP;
		req_ch.is_repeat <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= CFG_STEP_SPEED;
		cfg_ch.data      <= '0;

		// Reset state: sprite parked at the origin, still. Typed rows below follow
		// directly from that: walls at zero block, repeats and code 3 do nothing.
		add_chk(REQ_TICK,    DIR_UP,    1'b0, 0, 0,  0,  0, 1'b0, 1'b0);
		add_chk(REQ_PRESS,   DIR_UP,    1'b0, 0, 0,  0, -1, 1'b0, 1'b0);
		add_chk(REQ_TICK,    DIR_DOWN,  1'b0, 0, 0,  0, -1, 1'b0, 1'b1); // top wall
		add_chk(REQ_RELEASE, DIR_UP,    1'b0, 0, 0,  0,  0, 1'b0, 1'b0);
		add_chk(REQ_PRESS,   DIR_LEFT,  1'b0, 0, 0, -1,  0, 1'b0, 1'b0);
		add_chk(REQ_TICK,    DIR_LEFT,  1'b1, 0, 0, -1,  0, 1'b1, 1'b0); // left wall
		add_chk(REQ_PRESS,   DIR_RIGHT, 1'b1, 0, 0, -1,  0, 1'b0, 1'b0); // repeat key
		add_chk(REQ_RELEASE, DIR_DOWN,  1'b1, 0, 0, -1,  0, 1'b0, 1'b0);
		add_chk(REQ_RELEASE, DIR_LEFT,  1'b0, 0, 0,  0,  0, 1'b0, 1'b0);
		add_chk(REQ_UNUSED,  DIR_RIGHT, 1'b1, 0, 0,  0,  0, 1'b0, 1'b0);
		add_chk(REQ_UNUSED,  DIR_UP,    1'b0, 0, 0,  0,  0, 1'b0, 1'b0);
		add_chk(REQ_PRESS,   DIR_RIGHT, 1'b0, 0, 0,  1,  0, 1'b0, 1'b0);
		add_chk(REQ_PRESS,   DIR_DOWN,  1'b0, 0, 0,  1,  1, 1'b0, 1'b0);
		add_chk(REQ_TICK,    DIR_RIGHT, 1'b1, 1, 1,  1,  1, 1'b0, 1'b0); // tick ignores dir/rep
		// largest step: ramp x velocity into the +64 clamp
		add_reg(CFG_STEP_SPEED, 15);
		add_key(REQ_PRESS, DIR_RIGHT, 1'b0);
		add_key(REQ_PRESS, DIR_RIGHT, 1'b0);
		add_key(REQ_PRESS, DIR_RIGHT, 1'b0);
		add_key(REQ_PRESS, DIR_RIGHT, 1'b0);
		add_chk(REQ_PRESS, DIR_RIGHT, 1'b0, 1, 1, 64, 1, 1'b0, 1'b0);
		add_key(REQ_TICK,  DIR_UP,    1'b0);
		// obstacle right in the path: the x move hits, the y move is free
		add_reg(CFG_OTHER_X, 140);
		add_reg(CFG_OTHER_Y, 0);
		add_key(REQ_TICK,  DIR_UP,    1'b0);
		// step of zero: keys leave velocity alone
		add_reg(CFG_STEP_SPEED, 0);
		add_key(REQ_PRESS,   DIR_LEFT, 1'b0);
		add_key(REQ_RELEASE, DIR_UP,   1'b0);
		// obstacle in the far corner
		add_reg(CFG_OTHER_X, 620);
		add_reg(CFG_OTHER_Y, 460);
		add_key(REQ_TICK,  DIR_DOWN,  1'b0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].is_reg) begin
				settle();
				write_reg(directed[i].reg_idx, directed[i].reg_val);
			end else begin
				send_beat(directed[i].rtype, directed[i].dir, directed[i].rep,
					directed[i].typed, directed[i].want);
			end
		end

		// Random phases. Each one rewrites all three registers while idle; the
		// obstacle is mostly dropped near the predicted sprite so collisions and
		// near misses through the box corners are common.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 4)
				0:       write_reg(CFG_STEP_SPEED, 10'd15);
				1:       write_reg(CFG_STEP_SPEED, 10'd1);
				default: write_reg(CFG_STEP_SPEED, 10'($urandom_range(0, 15)));
			endcase
			if (p % 3 != 2) begin
				ox = sprite_px + int'($urandom_range(0, 60)) - 30;
				oy = sprite_py + int'($urandom_range(0, 60)) - 30;
				ox = (ox < 0) ? 0 : (ox > 620) ? 620 : ox;
				oy = (oy < 0) ? 0 : (oy > 460) ? 460 : oy;
			end else if (p % 2 == 0) begin
				ox = int'($urandom_range(0, 620));
				oy = int'($urandom_range(0, 460));
			end else begin
				ox = $urandom_range(0, 1) ? 620 : 0;
				oy = $urandom_range(0, 1) ? 460 : 0;
			end
			write_reg(CFG_OTHER_X, ox[9:0]);
			write_reg(CFG_OTHER_Y, oy[9:0]);

			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 3)
					rtype = REQ_UNUSED;
				else if (sel < 40)
					rtype = REQ_TICK;
				else if (sel < 72)
					rtype = REQ_PRESS;
				else
					rtype = REQ_RELEASE;
				dir = 2'($urandom_range(0, 3));
				rep = ($urandom_range(0, 7) == 0);
				send_beat(rtype, dir, rep, 1'b0, none);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sprite_move_with_box_collision.f =====
design/smbc_pkg.sv
design/smbc_if.sv
design/smbc_pair_test.sv
design/sprite_move_with_box_collision.sv
bench/sprite_move_with_box_collision_tb.sv
